// ----- hdl/amgs_pkg.sv -----
// Shared types and constants for the adjacency matrix graph store.
// Holds op and status codes, command/status structs between controller and datapath.
// No dependencies.
package amgs_pkg;

   localparam int unsigned MAX_VERTICES_DEF = 32;
   localparam int unsigned LABEL_W  = 8;
   localparam int unsigned OP_W     = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned KIND_W   = 2;

   localparam logic [OP_W-1:0] OP_ADD_VERTEX = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD_EDGE   = 2'd1;
   localparam logic [OP_W-1:0] OP_TEST_EDGE  = 2'd2;
   localparam logic [OP_W-1:0] OP_LIST       = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

   // response kinds loaded into the output register
   localparam logic [KIND_W-1:0] RSP_PLAIN = 2'd0;
   localparam logic [KIND_W-1:0] RSP_EDGE  = 2'd1;
   localparam logic [KIND_W-1:0] RSP_NBR   = 2'd2;

   typedef struct packed {
      logic                idx_clr;
      logic                idx_inc;
      logic                srch_rd;
      logic                lbl_rd;
      logic                add_vtx;
      logic                adj_rd_a;
      logic                adj_rd_b;
      logic                adj_wr_a;
      logic                adj_wr_b;
      logic                row_load;
      logic                row_clr_bit;
      logic                rsp_load;
      logic [KIND_W-1:0]   rsp_kind;
      logic [STATUS_W-1:0] rsp_status;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            idx_end;
      logic            chk_busy;
      logic            found_a;
      logic            found_b;
      logic            row_bit;
      logic            row_empty;
      logic            row_in_empty;
      logic            rsp_busy;
   } stat_type;

endpackage

// ----- hdl/amgs_req_if.sv -----
// Request channel of the graph store: valid/ready handshake with op and labels.
// Depends on amgs_pkg.
interface amgs_req_if;
   logic                          valid;
   logic                          ready;
   logic [amgs_pkg::OP_W-1:0]     op;
   logic [amgs_pkg::LABEL_W-1:0]  label_a;
   logic [amgs_pkg::LABEL_W-1:0]  label_b;

   modport source (output valid, output op, output label_a, output label_b, input ready);
   modport sink   (input valid, input op, input label_a, input label_b, output ready);
endinterface

// ----- hdl/amgs_rsp_if.sv -----
// Response channel of the graph store: valid/ready handshake with result fields.
// Depends on amgs_pkg.
interface amgs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [amgs_pkg::STATUS_W-1:0] status;
   logic                          edge_found;
   logic                          neighbour_valid;
   logic [amgs_pkg::LABEL_W-1:0]  neighbour_label;
   logic                          last;

   modport source (output valid, output status, output edge_found, output neighbour_valid,
                   output neighbour_label, output last, input ready);
   modport sink   (input valid, input status, input edge_found, input neighbour_valid,
                   input neighbour_label, input last, output ready);
endinterface

// ----- hdl/amgs_dpath.sv -----
// Datapath of the graph store: label and adjacency memories, slot counters,
// search flags, neighbour row register and the response register.
// Depends on amgs_pkg; driven by amgs_ctrl through cmd_type.
module amgs_dpath #(
   parameter int unsigned MAX_VERTICES = amgs_pkg::MAX_VERTICES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_take,
   input  logic [amgs_pkg::OP_W-1:0]     req_op,
   input  logic [amgs_pkg::LABEL_W-1:0]  req_label_a,
   input  logic [amgs_pkg::LABEL_W-1:0]  req_label_b,
   input  amgs_pkg::cmd_type             cmd,
   output amgs_pkg::stat_type            stat,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [amgs_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_edge_found,
   output logic                          rsp_neighbour_valid,
   output logic [amgs_pkg::LABEL_W-1:0]  rsp_neighbour_label,
   output logic                          rsp_last
);

   localparam int unsigned IW = $clog2(MAX_VERTICES);
   localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

   logic [amgs_pkg::LABEL_W-1:0] lbl_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0]      adj_mem [MAX_VERTICES];

   logic [amgs_pkg::OP_W-1:0]    op_ff;
   logic [amgs_pkg::LABEL_W-1:0] la_ff, lb_ff;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic                         chk_ff;
   logic                         found_a_ff, found_a_in, found_b_ff, found_b_in;
   logic [IW-1:0]                slot_a_ff, slot_a_in, slot_b_ff, slot_b_in;
   logic [amgs_pkg::LABEL_W-1:0] lbl_rd_ff;
   logic [IW-1:0]                lbl_addr_ff;
   logic [MAX_VERTICES-1:0]      adj_rd_ff;
   logic [MAX_VERTICES-1:0]      row_ff, row_in;
   logic [MAX_VERTICES-1:0]      cnt_mask;
   logic [MAX_VERTICES-1:0]      bit_a, bit_b;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [amgs_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic                          rsp_nv_ff, rsp_nv_in;
   logic [amgs_pkg::LABEL_W-1:0]  rsp_label_ff, rsp_label_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic          adj_we;
   logic [IW-1:0] adj_waddr, adj_raddr;
   logic [MAX_VERTICES-1:0] adj_wdata;

   always_comb begin
      for (int j = 0; j < int'(MAX_VERTICES); j++) begin
         cnt_mask[j] = (j < int'(count_ff));
      end
   end

   assign bit_a = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << slot_a_ff;
   assign bit_b = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << slot_b_ff;

   // label memory
   always_ff @(posedge clock) begin
      if (cmd.add_vtx) begin
         lbl_mem[count_ff[IW-1:0]] <= la_ff;
      end
      if (cmd.srch_rd || cmd.lbl_rd) begin
         lbl_rd_ff   <= lbl_mem[idx_ff[IW-1:0]];
         lbl_addr_ff <= idx_ff[IW-1:0];
      end
   end

   // adjacency memory; a new slot gets a cleared row
   always_comb begin
      adj_we    = cmd.add_vtx || cmd.adj_wr_a || cmd.adj_wr_b;
      adj_waddr = slot_a_ff;
      adj_wdata = adj_rd_ff | bit_b;
      if (cmd.add_vtx) begin
         adj_waddr = count_ff[IW-1:0];
         adj_wdata = '0;
      end else if (cmd.adj_wr_b) begin
         adj_waddr = slot_b_ff;
         adj_wdata = adj_rd_ff | bit_a;
      end
      adj_raddr = cmd.adj_rd_b ? slot_b_ff : slot_a_ff;
   end

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_waddr] <= adj_wdata;
      end
      if (cmd.adj_rd_a || cmd.adj_rd_b) begin
         adj_rd_ff <= adj_mem[adj_raddr];
      end
   end

   always_comb begin
      count_in = count_ff + CW'(cmd.add_vtx);

      idx_in = idx_ff;
      if (req_take || cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end

      found_a_in = found_a_ff;
      found_b_in = found_b_ff;
      slot_a_in  = slot_a_ff;
      slot_b_in  = slot_b_ff;
      if (req_take) begin
         found_a_in = 1'b0;
         found_b_in = 1'b0;
      end else if (chk_ff) begin
         // keep the lowest matching slot
         if (!found_a_ff && lbl_rd_ff == la_ff) begin
            found_a_in = 1'b1;
            slot_a_in  = lbl_addr_ff;
         end
         if (!found_b_ff && lbl_rd_ff == lb_ff) begin
            found_b_in = 1'b1;
            slot_b_in  = lbl_addr_ff;
         end
      end

      row_in = row_ff;
      if (cmd.row_load) begin
         row_in = adj_rd_ff & cnt_mask;
      end else if (cmd.row_clr_bit) begin
         row_in[idx_ff[IW-1:0]] = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_nv_in     = rsp_nv_ff;
      rsp_label_in  = rsp_label_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.rsp_status;
         rsp_found_in  = 1'b0;
         rsp_nv_in     = 1'b0;
         rsp_label_in  = '0;
         rsp_last_in   = 1'b1;
         unique case (cmd.rsp_kind)
            amgs_pkg::RSP_EDGE: begin
               rsp_status_in = amgs_pkg::ST_OK;
               rsp_found_in  = adj_rd_ff[slot_b_ff];
            end
            amgs_pkg::RSP_NBR: begin
               rsp_status_in = amgs_pkg::ST_OK;
               rsp_nv_in     = 1'b1;
               rsp_label_in  = lbl_rd_ff;
               rsp_last_in   = (row_ff == '0);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         chk_ff       <= 1'b0;
         found_a_ff   <= 1'b0;
         found_b_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         chk_ff       <= cmd.srch_rd;
         found_a_ff   <= found_a_in;
         found_b_ff   <= found_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff <= req_op;
         la_ff <= req_label_a;
         lb_ff <= req_label_b;
      end
      slot_a_ff     <= slot_a_in;
      slot_b_ff     <= slot_b_in;
      row_ff        <= row_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_nv_ff     <= rsp_nv_in;
      rsp_label_ff  <= rsp_label_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      stat.op           = op_ff;
      stat.full         = (count_ff == CW'(MAX_VERTICES));
      stat.idx_end      = (idx_ff == count_ff);
      stat.chk_busy     = chk_ff;
      stat.found_a      = found_a_ff;
      stat.found_b      = found_b_ff;
      stat.row_bit      = row_ff[idx_ff[IW-1:0]];
      stat.row_empty    = (row_ff == '0);
      stat.row_in_empty = ((adj_rd_ff & cnt_mask) == '0);
      stat.rsp_busy     = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_edge_found      = rsp_found_ff;
   assign rsp_neighbour_valid = rsp_nv_ff;
   assign rsp_neighbour_label = rsp_label_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

// ----- hdl/amgs_ctrl.sv -----
// Controller of the graph store: sequences vertex add, search, edge update, edge test and
// neighbour walk. Depends on amgs_pkg; commands amgs_dpath via cmd_type.
module amgs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               req_take,
   input  amgs_pkg::stat_type stat,
   output amgs_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_START   = 4'd1;
   localparam logic [3:0] S_SEARCH  = 4'd2;
   localparam logic [3:0] S_DECIDE  = 4'd3;
   localparam logic [3:0] S_WR_A    = 4'd4;
   localparam logic [3:0] S_RD_B    = 4'd5;
   localparam logic [3:0] S_WR_B    = 4'd6;
   localparam logic [3:0] S_RESP_OK = 4'd7;
   localparam logic [3:0] S_TEST    = 4'd8;
   localparam logic [3:0] S_LOAD    = 4'd9;
   localparam logic [3:0] S_WALK    = 4'd10;
   localparam logic [3:0] S_EMIT    = 4'd11;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_START;
            end
         end
         S_START: begin
            if (stat.op == amgs_pkg::OP_ADD_VERTEX) begin
               if (!stat.rsp_busy) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_kind   = amgs_pkg::RSP_PLAIN;
                  cmd.rsp_status = stat.full ? amgs_pkg::ST_FULL : amgs_pkg::ST_OK;
                  cmd.add_vtx    = !stat.full;
                  state_in       = S_IDLE;
               end
            end else begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (!stat.idx_end) begin
               cmd.srch_rd = 1'b1;
               cmd.idx_inc = 1'b1;
            end else if (!stat.chk_busy) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!stat.found_a || (stat.op != amgs_pkg::OP_LIST && !stat.found_b)) begin
               if (!stat.rsp_busy) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_kind   = amgs_pkg::RSP_PLAIN;
                  cmd.rsp_status = amgs_pkg::ST_UNKNOWN;
                  state_in       = S_IDLE;
               end
            end else begin
               cmd.adj_rd_a = 1'b1;
               if (stat.op == amgs_pkg::OP_ADD_EDGE) begin
                  state_in = S_WR_A;
               end else if (stat.op == amgs_pkg::OP_TEST_EDGE) begin
                  state_in = S_TEST;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_WR_A: begin
            cmd.adj_wr_a = 1'b1;
            state_in     = S_RD_B;
         end
         S_RD_B: begin
            cmd.adj_rd_b = 1'b1;
            state_in     = S_WR_B;
         end
         S_WR_B: begin
            cmd.adj_wr_b = 1'b1;
            state_in     = S_RESP_OK;
         end
         S_RESP_OK: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_kind   = amgs_pkg::RSP_PLAIN;
               cmd.rsp_status = amgs_pkg::ST_OK;
               state_in       = S_IDLE;
            end
         end
         S_TEST: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = amgs_pkg::RSP_EDGE;
               state_in     = S_IDLE;
            end
         end
         S_LOAD: begin
            if (stat.row_in_empty) begin
               if (!stat.rsp_busy) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_kind   = amgs_pkg::RSP_PLAIN;
                  cmd.rsp_status = amgs_pkg::ST_OK;
                  state_in       = S_IDLE;
               end
            end else begin
               cmd.row_load = 1'b1;
               cmd.idx_clr  = 1'b1;
               state_in     = S_WALK;
            end
         end
         S_WALK: begin
            if (stat.row_bit) begin
               cmd.lbl_rd      = 1'b1;
               cmd.row_clr_bit = 1'b1;
               state_in        = S_EMIT;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_EMIT: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = amgs_pkg::RSP_NBR;
               if (stat.row_empty) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_WALK;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/adjacency_matrix_graph_store.sv -----
// Undirected graph store, top level: request and response channels,
// controller and datapath. Depends on amgs_pkg, amgs_req_if, amgs_rsp_if,
// amgs_ctrl and amgs_dpath.
//
// Usage: a request (op, label_a, label_b) is taken on req_bus when valid and
// ready are high. Ops: add vertex, add edge, test edge, list neighbours.
// Every request gives one response on rsp_bus, except a listing that gives
// one response per neighbour in slot order; the final one has last set.
// After a request is accepted, add vertex responds from the start state.
// Edge ops and listings first scan the label memory one slot per cycle;
// then an unknown label is answered from the decide state, add edge sets
// the edge bit in row a, then in row b, test edge reads row a, and a listing
// reads row a and walks it one slot per cycle, stopping at each neighbour
// to read and emit its label; an emit waits while a response is stalled.
// Ready is high only between requests, from the edge that loads the last
// response on. The single label memory read port sets the pace.
// Reset clears the vertex count; rows are cleared as vertices are added,
// so the block takes requests right after reset.
// A stalled response holds in the output register; the next request is
// taken meanwhile, and its work waits only when it needs to respond.
module adjacency_matrix_graph_store #(
   parameter int unsigned MAX_VERTICES = amgs_pkg::MAX_VERTICES_DEF
) (
   input logic        clock,
   input logic        reset,
   amgs_req_if.sink   req_bus,
   amgs_rsp_if.source rsp_bus
);

   amgs_pkg::cmd_type  cmd;
   amgs_pkg::stat_type stat;
   logic               req_take;

   amgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req_take  (req_take),
      .stat      (stat),
      .cmd       (cmd)
   );

   amgs_dpath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_take            (req_take),
      .req_op              (req_bus.op),
      .req_label_a         (req_bus.label_a),
      .req_label_b         (req_bus.label_b),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_valid           (rsp_bus.valid),
      .rsp_ready           (rsp_bus.ready),
      .rsp_status          (rsp_bus.status),
      .rsp_edge_found      (rsp_bus.edge_found),
      .rsp_neighbour_valid (rsp_bus.neighbour_valid),
      .rsp_neighbour_label (rsp_bus.neighbour_label),
      .rsp_last            (rsp_bus.last)
   );

endmodule

// ----- test/amgs_graph_checker.sv -----
`timescale 1ns / 1ps
// Response checker for the graph store: mirrors the vertex table and adjacency rows,
// predicts the responses of each accepted request and compares them in order.
// Depends on amgs_pkg, amgs_req_if and amgs_rsp_if.
module amgs_graph_checker import amgs_pkg::*; #(
   parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic clock,
   input  logic reset,
   amgs_req_if  req_mon,
   amgs_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   pending_count
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                edge_found;
      logic                nbr_valid;
      logic [LABEL_W-1:0]  nbr_label;
      logic                last;
   } graph_rsp_type;

   logic [LABEL_W-1:0]      slot_label [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] slot_row   [MAX_VERTICES];
   int unsigned             slot_count;
   graph_rsp_type           expected_rsps [$];

   function automatic graph_rsp_type make_rsp(input logic [STATUS_W-1:0] status,
                                              input logic found, input logic nv,
                                              input logic [LABEL_W-1:0] lbl,
                                              input logic last);
      graph_rsp_type r;
      r.status     = status;
      r.edge_found = found;
      r.nbr_valid  = nv;
      r.nbr_label  = lbl;
      r.last       = last;
      return r;
   endfunction

   // lowest occupied slot holding the label
   function automatic bit find_slot(input logic [LABEL_W-1:0] lbl, output int unsigned slot);
      int unsigned i;
      bit          hit;
      hit  = 1'b0;
      slot = 0;
      for (i = 0; i < slot_count; i++) begin
         if (!hit && slot_label[i] == lbl) begin
            hit  = 1'b1;
            slot = i;
         end
      end
      return hit;
   endfunction

   task automatic predict_request(input logic [OP_W-1:0] op, input logic [LABEL_W-1:0] la,
                                  input logic [LABEL_W-1:0] lb);
      int unsigned sa, sb, i, total, k;
      bit          ka, kb;
      ka = find_slot(la, sa);
      kb = find_slot(lb, sb);
      case (op)
         OP_ADD_VERTEX: begin
            if (slot_count >= MAX_VERTICES) begin
               expected_rsps.push_back(make_rsp(ST_FULL, 1'b0, 1'b0, '0, 1'b1));
            end else begin
               slot_label[slot_count] = la;
               slot_row[slot_count]   = '0;
               slot_count++;
               expected_rsps.push_back(make_rsp(ST_OK, 1'b0, 1'b0, '0, 1'b1));
            end
         end
         OP_ADD_EDGE, OP_TEST_EDGE: begin
            if (!(ka && kb)) begin
               expected_rsps.push_back(make_rsp(ST_UNKNOWN, 1'b0, 1'b0, '0, 1'b1));
            end else if (op == OP_ADD_EDGE) begin
               slot_row[sa][sb] = 1'b1;
               slot_row[sb][sa] = 1'b1;
               expected_rsps.push_back(make_rsp(ST_OK, 1'b0, 1'b0, '0, 1'b1));
            end else begin
               expected_rsps.push_back(make_rsp(ST_OK, slot_row[sa][sb], 1'b0, '0, 1'b1));
            end
         end
         OP_LIST: begin
            if (!ka) begin
               expected_rsps.push_back(make_rsp(ST_UNKNOWN, 1'b0, 1'b0, '0, 1'b1));
            end else begin
               total = $countones(slot_row[sa]);
               if (total == 0) begin
                  expected_rsps.push_back(make_rsp(ST_OK, 1'b0, 1'b0, '0, 1'b1));
               end else begin
                  k = 0;
                  for (i = 0; i < slot_count; i++) begin
                     if (slot_row[sa][i]) begin
                        k++;
                        expected_rsps.push_back(make_rsp(ST_OK, 1'b0, 1'b1, slot_label[i],
                                                         k == total));
                     end
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_response();
      graph_rsp_type got, want;
      got = make_rsp(rsp_mon.status, rsp_mon.edge_found, rsp_mon.neighbour_valid,
                     rsp_mon.neighbour_label, rsp_mon.last);
      if (expected_rsps.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected response: status=%0d found=%0b nv=%0b label=%02h last=%0b",
                     got.status, got.edge_found, got.nbr_valid, got.nbr_label, got.last);
      end else begin
         want = expected_rsps.pop_front();
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $write("response mismatch: exp status=%0d found=%0b nv=%0b label=%02h last=%0b",
                      want.status, want.edge_found, want.nbr_valid, want.nbr_label,
                      want.last);
               $display(", got status=%0d found=%0b nv=%0b label=%02h last=%0b",
                        got.status, got.edge_found, got.nbr_valid, got.nbr_label, got.last);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mismatch_count = 0;
         pending_count  = 0;
         slot_count     = 0;
         expected_rsps.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_response();
         if (req_mon.valid && req_mon.ready)
            predict_request(req_mon.op, req_mon.label_a, req_mon.label_b);
         pending_count = expected_rsps.size();
      end
   end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the graph store testbench: clock, reset, request stimulus, response back-pressure,
// watchdog and verdict. Depends on amgs_pkg, the channel interfaces, the block
// and amgs_graph_checker.
module tb_top;
   import amgs_pkg::*;

   localparam int unsigned MAX_VERTICES = MAX_VERTICES_DEF;
   localparam int unsigned RANDOM_REQS  = 357;
   localparam int unsigned DRAIN_CYCLES = 3 * MAX_VERTICES + 24;
   localparam int unsigned QUIET_LIMIT  = 3000;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   pending_count;
   int   quiet_cycles = 0;
   bit   req_calm = 1'b0;
   bit   rsp_calm = 1'b0;

   logic [LABEL_W-1:0] added_labels [$];
   int unsigned        adds_sent = 0;

   amgs_req_if req_bus ();
   amgs_rsp_if rsp_bus ();

   adjacency_matrix_graph_store #(.MAX_VERTICES(MAX_VERTICES)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   amgs_graph_checker #(.MAX_VERTICES(MAX_VERTICES)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // mostly short idles, a few long ones
   function automatic int unsigned pick_gap(input bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [LABEL_W-1:0] pick_label();
      if (added_labels.size() == 0 || $urandom_range(0, 99) < 15)
         return LABEL_W'($urandom_range(0, 255));
      return added_labels[$urandom_range(0, added_labels.size() - 1)];
   endfunction

   task automatic send_req(input logic [OP_W-1:0] op, input logic [LABEL_W-1:0] la,
                           input logic [LABEL_W-1:0] lb);
      int unsigned gap;
      gap = pick_gap(req_calm);
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.op      = op;
      req_bus.label_a = la;
      req_bus.label_b = lb;
      req_bus.valid   = 1'b1;
      if (op == OP_ADD_VERTEX && adds_sent < MAX_VERTICES) begin
         added_labels.push_back(la);
         adds_sent++;
      end
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // response back-pressure
   initial begin
      int unsigned stall, cyc;
      rsp_bus.ready = 1'b0;
      stall = 0;
      cyc   = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc % 200 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
         if (stall != 0) begin
            rsp_bus.ready = 1'b0;
            stall--;
         end else begin
            rsp_bus.ready = 1'b1;
            stall = pick_gap(rsp_calm);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned        i, r;
      logic [OP_W-1:0]    op;
      logic [LABEL_W-1:0] la, lb;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.op      = OP_ADD_VERTEX;
      req_bus.label_a = '0;
      req_bus.label_b = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty table, extremes, duplicates, self edge, empty listing
      send_req(OP_LIST,       8'h00, 8'hFF);
      send_req(OP_ADD_EDGE,   8'hFF, 8'h00);
      send_req(OP_TEST_EDGE,  8'h00, 8'h00);
      send_req(OP_ADD_VERTEX, 8'h00, 8'hFF);
      send_req(OP_ADD_VERTEX, 8'hFF, 8'h00);
      send_req(OP_ADD_VERTEX, 8'hA5, 8'h5A);
      send_req(OP_ADD_VERTEX, 8'h00, 8'hFF);
      send_req(OP_ADD_VERTEX, 8'h5A, 8'hA5);
      send_req(OP_LIST,       8'h00, 8'hFF);
      send_req(OP_ADD_EDGE,   8'h00, 8'hFF);
      send_req(OP_ADD_EDGE,   8'hA5, 8'hA5);
      send_req(OP_TEST_EDGE,  8'hFF, 8'h00);
      send_req(OP_TEST_EDGE,  8'h00, 8'hA5);
      send_req(OP_TEST_EDGE,  8'hA5, 8'hA5);
      send_req(OP_LIST,       8'hA5, 8'h00);
      send_req(OP_LIST,       8'h00, 8'h00);
      send_req(OP_ADD_EDGE,   8'h5A, 8'h3C);
      send_req(OP_ADD_EDGE,   8'h3C, 8'h5A);
      send_req(OP_TEST_EDGE,  8'h5A, 8'h3C);
      send_req(OP_LIST,       8'h77, 8'hFF);
      send_req(OP_ADD_EDGE,   8'h5A, 8'h00);
      send_req(OP_ADD_EDGE,   8'h5A, 8'hA5);
      send_req(OP_LIST,       8'h5A, 8'h00);

      for (i = 0; i < RANDOM_REQS; i++) begin
         if (i % 30 == 0) req_calm = ($urandom_range(0, 3) == 0);
         r  = $urandom_range(0, 99);
         lb = pick_label();
         if (r < ((adds_sent < MAX_VERTICES) ? 20 : 4)) begin
            op = OP_ADD_VERTEX;
            la = ($urandom_range(0, 99) < 70 || added_labels.size() == 0) ?
                 LABEL_W'($urandom_range(0, 255)) :
                 added_labels[$urandom_range(0, added_labels.size() - 1)];
            lb = LABEL_W'($urandom_range(0, 255));
         end else if (r < 55) begin
            op = OP_ADD_EDGE;
            // a hub vertex collects long neighbour lists
            la = (added_labels.size() != 0 && $urandom_range(0, 99) < 30) ?
                 added_labels[0] : pick_label();
         end else if (r < 75) begin
            op = OP_TEST_EDGE;
            la = pick_label();
         end else begin
            op = OP_LIST;
            la = ($urandom_range(0, 99) < 30 && added_labels.size() != 0) ?
                 added_labels[0] : pick_label();
            lb = LABEL_W'($urandom_range(0, 255));
         end
         send_req(op, la, lb);
      end
      req_bus.valid = 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/amgs_pkg.sv
hdl/amgs_req_if.sv
hdl/amgs_rsp_if.sv
hdl/amgs_dpath.sv
hdl/amgs_ctrl.sv
hdl/adjacency_matrix_graph_store.sv
test/amgs_graph_checker.sv
test/tb_top.sv
